// ===== rtl/core/sswi_pkg.sv =====
// Shared types and constants for the sliding sample window interpolator.
// Used by every module under rtl/core except sswi_ram; depends on nothing else.
`timescale 1ns / 1ps

package sswi_pkg;

    localparam int WINDOW_DEPTH_DEF = 256;

    localparam int SPACING_W = 31;
    localparam int LENGTH_W  = 9;
    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 1;
    localparam int DIV_W     = 64;
    localparam int QUOT_W    = 33;
    localparam int DCNT_W    = 7;

    localparam logic [CFG_IDX_W-1:0] REG_SPACING = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 1'b1;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [SPACING_W-1:0] SPACING_RST = 31'd65536;
    localparam logic [LENGTH_W-1:0]  LENGTH_RST  = 9'd256;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] time_req;
        logic signed [DATA_W-1:0] sample_value;
    } item_t;

endpackage

// ===== rtl/core/sswi_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the sample store.
`timescale 1ns / 1ps

module sswi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/sswi_fifo.sv =====
// Two-entry queue between the accepting front and the executing back end.
// Depends on sswi_pkg for the item type.
`timescale 1ns / 1ps

module sswi_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sswi_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output sswi_pkg::item_t head
);
    import sswi_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/sswi_div.sv =====
// Restoring divider, one quotient bit per cycle, for an unsigned dividend
// whose quotient is known to fit in nbits. Depends on sswi_pkg.
`timescale 1ns / 1ps

module sswi_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [sswi_pkg::DIV_W-1:0]         dividend,
    input  logic [sswi_pkg::DCNT_W-1:0]        nbits,
    input  logic [sswi_pkg::SPACING_W-1:0]     divisor,
    output logic                               done,
    output logic [sswi_pkg::QUOT_W-1:0]        quot,
    output logic [sswi_pkg::SPACING_W-1:0]     rem
);
    import sswi_pkg::*;

    logic [SPACING_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0]     dvd_reg, dvd_next;
    logic [QUOT_W-1:0]    quot_reg, quot_next;
    logic [DCNT_W-1:0]    cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [SPACING_W:0]   trial;
    logic                 fits;

    assign trial = {rem_reg, dvd_reg[DIV_W-1]};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            // The quotient fits in nbits, so the bits above them are
            // already smaller than the divisor.
            rem_next  = SPACING_W'(dividend >> nbits);
            dvd_next  = dividend << (DCNT_W'(DIV_W) - nbits);
            quot_next = '0;
            cnt_next  = nbits;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? SPACING_W'(trial - {1'b0, divisor}) : trial[SPACING_W-1:0];
            dvd_next  = dvd_reg << 1;
            quot_next = {quot_reg[QUOT_W-2:0], fits};
            cnt_next  = cnt_reg - DCNT_W'(1);
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/core/sswi_back.sv =====
// Back end: executes appends and interpolating queries against the sample
// ring. Depends on sswi_pkg, sswi_ram and sswi_div.
`timescale 1ns / 1ps

module sswi_back #(
    parameter int WINDOW_DEPTH = sswi_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    input  sswi_pkg::item_t                      item,
    output logic                                 item_pop,
    input  logic [sswi_pkg::SPACING_W-1:0]       spacing,
    input  logic [$clog2(WINDOW_DEPTH+1)-1:0]    length,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [sswi_pkg::DATA_W-1:0]   value,
    output logic                                 in_range
);
    import sswi_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam int PW = SPACING_W + FW;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_ADD1    = 11'b00000000010,
        S_ADD2    = 11'b00000000100,
        S_QPROD   = 11'b00000001000,
        S_QRANGE  = 11'b00000010000,
        S_QDIV1   = 11'b00000100000,
        S_QRDA    = 11'b00001000000,
        S_QRDB    = 11'b00010000000,
        S_QMUL    = 11'b00100000000,
        S_QLAUNCH = 11'b01000000000,
        S_QDIV2   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic   qout_reg, qout_next;

    item_t                    item_reg;
    logic [AW-1:0]            ptr_reg, ptr_next;
    logic [FW-1:0]            fill_reg, fill_next;
    logic signed [DATA_W-1:0] newest_reg, newest_next;
    logic [PW-1:0]            prod_reg;
    logic [AW-1:0]            idx_reg;
    logic [SPACING_W-1:0]     frac_reg;
    logic                     last_reg;
    logic signed [DATA_W-1:0] a_reg;
    logic                     neg_reg;
    logic [DIV_W-1:0]         mprod_reg;
    logic signed [DATA_W-1:0] res_value_reg;
    logic                     res_range_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    logic                     out_range_reg;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr, ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;

    logic                     div_start;
    logic [DIV_W-1:0]         div_dividend;
    logic [DCNT_W-1:0]        div_nbits;
    logic                     div_done;
    logic [QUOT_W-1:0]        div_quot;
    logic [SPACING_W-1:0]     div_rem;

    logic [FW-1:0]            fill_base, drop;
    logic [AW-1:0]            ptr_base;
    logic signed [DIV_W-1:0]  t_wide, start_wide;
    logic                     range_ok;
    logic signed [DATA_W:0]   diff;
    logic [DATA_W:0]          diff_mag;
    logic signed [DATA_W+1:0] y_wide;
    logic                     load_out;

    function automatic logic [AW-1:0] ring_add(logic [AW-1:0] base, logic [FW:0] ofs);
        logic [FW+1:0] sum;
        sum = (FW+2)'(base) + (FW+2)'(ofs);
        if (sum >= (FW+2)'(WINDOW_DEPTH))
        begin
            sum = sum - (FW+2)'(WINDOW_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    sswi_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item_reg.sample_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sswi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .nbits    (div_nbits),
        .divisor  (spacing),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // Append: restart the ring when time runs backwards, then trim to the length.
    always_comb
    begin
        if (item_reg.time_req < newest_reg)
        begin
            fill_base = '0;
            ptr_base  = '0;
        end
        else
        begin
            fill_base = fill_reg;
            ptr_base  = ptr_reg;
        end
        drop = fill_base - length + FW'(1);
    end

    assign t_wide     = DIV_W'(item_reg.time_req);
    assign start_wide = DIV_W'(newest_reg) - $signed({{(DIV_W-PW){1'b0}}, prod_reg});
    assign range_ok   = (item_reg.time_req <= newest_reg) && (t_wide >= start_wide);

    assign diff     = $signed({ram_rdata[DATA_W-1], ram_rdata}) - $signed({a_reg[DATA_W-1], a_reg});
    assign diff_mag = diff[DATA_W] ? (DATA_W+1)'(0) - diff : diff;

    // Floor division: round the magnitude up when the difference is negative.
    assign y_wide = neg_reg
        ? $signed({{2{a_reg[DATA_W-1]}}, a_reg}) - $signed({1'b0, div_quot})
          - $signed({{(DATA_W+1){1'b0}}, (div_rem != '0)})
        : $signed({{2{a_reg[DATA_W-1]}}, a_reg}) + $signed({1'b0, div_quot});

    assign load_out = qout_reg && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next   = state_reg;
        qout_next    = qout_reg;
        ptr_next     = ptr_reg;
        fill_next    = fill_reg;
        newest_next  = newest_reg;
        item_pop     = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = ring_add(ptr_reg, {1'b0, fill_reg});
        ram_raddr    = '0;
        div_start    = 1'b0;
        div_dividend = DIV_W'(t_wide - start_wide);
        div_nbits    = DCNT_W'(AW);
        if (qout_reg)
        begin
            if (load_out)
            begin
                qout_next  = 1'b0;
                state_next = S_IDLE;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        item_pop   = 1'b1;
                        state_next = (item.kind == KIND_ADD) ? S_ADD1 : S_QPROD;
                    end
                end
                S_ADD1:
                begin
                    newest_next = item_reg.time_req;
                    if (fill_base >= length)
                    begin
                        ptr_next  = ring_add(ptr_base, {1'b0, drop});
                        fill_next = length - FW'(1);
                    end
                    else
                    begin
                        ptr_next  = ptr_base;
                        fill_next = fill_base;
                    end
                    state_next = S_ADD2;
                end
                S_ADD2:
                begin
                    ram_we     = 1'b1;
                    fill_next  = fill_reg + FW'(1);
                    state_next = S_IDLE;
                end
                S_QPROD:
                begin
                    if (fill_reg == '0)
                    begin
                        qout_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_QRANGE;
                    end
                end
                S_QRANGE:
                begin
                    if (range_ok)
                    begin
                        div_start  = 1'b1;
                        state_next = S_QDIV1;
                    end
                    else
                    begin
                        qout_next = 1'b1;
                    end
                end
                S_QDIV1:
                begin
                    if (div_done)
                    begin
                        state_next = S_QRDA;
                    end
                end
                S_QRDA:
                begin
                    ram_raddr  = last_reg ? ring_add(ptr_reg, {1'b0, fill_reg - FW'(1)})
                                          : ring_add(ptr_reg, (FW+1)'(idx_reg));
                    state_next = S_QRDB;
                end
                S_QRDB:
                begin
                    ram_raddr = ring_add(ptr_reg, (FW+1)'(idx_reg) + (FW+1)'(1));
                    if (last_reg)
                    begin
                        qout_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_QMUL;
                    end
                end
                S_QMUL:
                begin
                    state_next = S_QLAUNCH;
                end
                S_QLAUNCH:
                begin
                    div_start    = 1'b1;
                    div_dividend = mprod_reg;
                    div_nbits    = DCNT_W'(QUOT_W);
                    state_next   = S_QDIV2;
                end
                S_QDIV2:
                begin
                    if (div_done)
                    begin
                        qout_next = 1'b1;
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            qout_reg      <= 1'b0;
            ptr_reg       <= '0;
            fill_reg      <= '0;
            newest_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            qout_reg   <= qout_next;
            ptr_reg    <= ptr_next;
            fill_reg   <= fill_next;
            newest_reg <= newest_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            item_reg <= item;
        end
        if (!qout_reg)
        begin
            case (state_reg)
                S_QPROD:
                begin
                    prod_reg      <= PW'(spacing) * PW'(fill_reg - FW'(1));
                    res_value_reg <= '0;
                    res_range_reg <= 1'b0;
                end
                S_QDIV1:
                begin
                    idx_reg  <= div_quot[AW-1:0];
                    frac_reg <= div_rem;
                    last_reg <= ({1'b0, div_quot[AW-1:0]} >= (fill_reg - FW'(1)));
                end
                S_QRDB:
                begin
                    a_reg         <= ram_rdata;
                    res_value_reg <= ram_rdata;
                    res_range_reg <= 1'b1;
                end
                S_QMUL:
                begin
                    neg_reg   <= diff[DATA_W];
                    mprod_reg <= DIV_W'(diff_mag) * DIV_W'(frac_reg);
                end
                S_QDIV2:
                begin
                    res_value_reg <= y_wide[DATA_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
        if (load_out)
        begin
            out_value_reg <= res_value_reg;
            out_range_reg <= res_range_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = out_value_reg;
    assign in_range  = out_range_reg;

endmodule

// ===== rtl/core/sliding_sample_window_interpolator.sv =====
// Top level: configuration registers, input queue and the executing back end.
// Depends on sswi_pkg, sswi_fifo and sswi_back.
`timescale 1ns / 1ps

// Keeps the last window_length samples of a uniformly spaced trace and answers
// queries by linear interpolation, rounded toward minus infinity. One item is
// worked on at a time behind a two-beat input queue. Queries use the bit-serial
// divider, which runs once to find the sample index and, unless the query falls
// on the newest sample, once more to scale the interpolated step. Queries into an
// empty window or outside it return zero with in_range low. Configuration must be
// written only while the block is idle; the block itself does not enforce
// this, so the user is bound to keep to it.
module sliding_sample_window_interpolator #(
    parameter int WINDOW_DEPTH = sswi_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [sswi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sswi_pkg::SPACING_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic signed [sswi_pkg::DATA_W-1:0]  time_req,
    input  logic signed [sswi_pkg::DATA_W-1:0]  sample_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [sswi_pkg::DATA_W-1:0]  value,
    output logic                                in_range
);
    import sswi_pkg::*;

    localparam int FW = $clog2(WINDOW_DEPTH + 1);

    logic [SPACING_W-1:0] spacing_reg;
    logic [LENGTH_W-1:0]  length_reg;
    logic [SPACING_W-1:0] spacing_eff;
    logic [FW-1:0]        length_eff;
    item_t                in_item, head;
    logic                 q_full, q_empty, q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg <= SPACING_RST;
            length_reg  <= LENGTH_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SPACING: spacing_reg <= cfg_data;
                REG_LENGTH:  length_reg  <= cfg_data[LENGTH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // A zero spacing acts as the smallest step, and the length is clamped to
    // between one and the storage depth.
    assign spacing_eff = (spacing_reg == '0) ? SPACING_W'(1) : spacing_reg;

    always_comb
    begin
        if (length_reg == '0)
        begin
            length_eff = FW'(1);
        end
        else if (32'(length_reg) > 32'(WINDOW_DEPTH))
        begin
            length_eff = FW'(WINDOW_DEPTH);
        end
        else
        begin
            length_eff = FW'(length_reg);
        end
    end

    assign in_item.kind         = kind;
    assign in_item.time_req     = time_req;
    assign in_item.sample_value = sample_value;
    assign in_stall             = q_full;

    sswi_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !q_full),
        .push_item (in_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (head)
    );

    sswi_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (!q_empty),
        .item       (head),
        .item_pop   (q_pop),
        .spacing    (spacing_eff),
        .length     (length_eff),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value      (value),
        .in_range   (in_range)
    );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for sliding_sample_window_interpolator.
// Depends on sswi_pkg and the RTL; a predictor in this file works out every query result.
`timescale 1ns / 1ps

module testbench;
    import sswi_pkg::*;

    localparam int DEPTH = 256;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = REG_SPACING;
    logic [SPACING_W-1:0]     cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     kind = KIND_ADD;
    logic signed [DATA_W-1:0] time_req = '0;
    logic signed [DATA_W-1:0] sample_value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] value;
    logic                     in_range;

    sliding_sample_window_interpolator i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
        .time_req(time_req), .sample_value(sample_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .value(value), .in_range(in_range)
    );

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     in_range;
    } answer_t;

    // Predictor copy of the block state.
    logic signed [DATA_W-1:0] trace [DEPTH];
    int unsigned              head_idx = 0;
    int unsigned              fill = 0;
    longint                   last_time = 0;
    logic [SPACING_W-1:0]     spacing_reg = SPACING_RST;
    logic [LENGTH_W-1:0]      length_reg = LENGTH_RST;

    item_t   pending_items[$];
    answer_t expected_answers[$];
    item_t   cur_item;
    int      items_pushed = 0;
    int      items_taken = 0;
    int      answers_seen = 0;
    int      errors = 0;
    int      cycle_no = 0;
    int      hold_left = 0;
    bit      hold_done = 0;

    // Generator view of the window, used only to aim items at useful times.
    longint  gen_time = 0;
    int      gen_fill = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
        $display("mismatch on %s: expected %0d, got %0d at %0t", what, exp_v, got_v, $realtime);
        errors++;
    endtask

    task automatic interpolate_and_store(input item_t it);
        longint  sp, start, offset, idx, frac, a, b, num, y, t;
        int unsigned len;
        answer_t ans;
        t = it.time_req;
        if (it.kind == KIND_ADD) begin
            len = (length_reg == 0) ? 1 : (length_reg > DEPTH) ? DEPTH : length_reg;
            if (t < last_time) begin
                fill = 0;
                head_idx = 0;
            end
            last_time = t;
            if (fill >= len) begin
                head_idx = (head_idx + fill - len + 1) % DEPTH;
                fill = len - 1;
            end
            trace[(head_idx + fill) % DEPTH] = it.sample_value;
            fill++;
            return;
        end
        ans.value = '0;
        ans.in_range = 1'b0;
        sp = (spacing_reg == 0) ? 1 : longint'(spacing_reg);
        if (fill > 0) begin
            start = last_time - sp * longint'(fill - 1);
            if (t <= last_time && t >= start) begin
                offset = t - start;
                idx = offset / sp;
                frac = offset - idx * sp;
                if (idx >= fill - 1) begin
                    y = trace[(head_idx + fill - 1) % DEPTH];
                end
                else begin
                    a = trace[(head_idx + idx) % DEPTH];
                    b = trace[(head_idx + idx + 1) % DEPTH];
                    num = a * (sp - frac) + b * frac;
                    y = num / sp;
                    if (num % sp != 0 && num < 0)
                        y--;
                end
                if (y > 64'sh7FFFFFFF) y = 64'sh7FFFFFFF;
                if (y < -64'sh80000000) y = -64'sh80000000;
                ans.value = y[31:0];
                ans.in_range = 1'b1;
            end
        end
        expected_answers.insert(expected_answers.size(), ans);
    endtask

    // Stimulus side: a beat leaves only when accepted, and a held payload stays put.
    always @(posedge clk) begin
        cycle_no <= cycle_no + 1;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                interpolate_and_store(cur_item);
                items_taken++;
            end
            if (!in_valid || !in_stall) begin
                if (pending_items.size() > 0 &&
                    ((cycle_no > 3000 && cycle_no < 9000) || $urandom_range(99) >= 23)) begin
                    cur_item = pending_items[0];
                    pending_items.delete(0);
                    in_valid <= 1'b1;
                    kind <= cur_item.kind;
                    time_req <= cur_item.time_req;
                    sample_value <= cur_item.sample_value;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result side with random stalls and one long hold-off.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                answers_seen++;
                if (expected_answers.size() == 0) begin
                    report_mismatch("unexpected beat", 0, value);
                end
                else begin
                    if (value !== expected_answers[0].value)
                        report_mismatch("value", expected_answers[0].value, value);
                    if (in_range !== expected_answers[0].in_range)
                        report_mismatch("in_range", expected_answers[0].in_range, in_range);
                    expected_answers.delete(0);
                end
            end
            if (!hold_done && answers_seen >= 150) begin
                hold_done = 1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else begin
                out_stall <= (cycle_no > 12000 && cycle_no < 18000) ? 1'b0 :
                             ($urandom_range(99) < 23);
            end
        end
    end

    task automatic push_item(input logic k, input longint t, input logic [31:0] v);
        item_t it;
        it.kind = k;
        it.time_req = t[31:0];
        it.sample_value = v;
        pending_items.insert(pending_items.size(), it);
        items_pushed++;
    endtask

    task automatic wait_idle();
        while (items_taken != items_pushed || expected_answers.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_config(input logic [SPACING_W-1:0] sp, input logic [LENGTH_W-1:0] len);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_SPACING;
        cfg_data <= sp;
        @(posedge clk);
        cfg_index <= REG_LENGTH;
        cfg_data <= SPACING_W'(len);
        @(posedge clk);
        cfg_write <= 1'b0;
        spacing_reg = sp;
        length_reg = len;
    endtask

    // Mostly evenly spaced appends and queries aimed inside the window, with some noise.
    task automatic fill_random(input int n, input int add_pct, input int queries_first);
        longint sp, t, lo;
        int     pick, len;
        logic [31:0] v;
        sp = (spacing_reg == 0) ? 1 : longint'(spacing_reg);
        len = (length_reg == 0) ? 1 : (length_reg > DEPTH) ? DEPTH : length_reg;
        for (int n_i = 0; n_i < n; n_i++) begin
            pick = $urandom_range(99);
            v = $urandom;
            if ($urandom_range(19) == 0)
                v = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
            if (n_i >= queries_first && $urandom_range(99) < add_pct) begin
                if (pick < 85) t = gen_time + sp;
                else if (pick < 90) t = gen_time;
                else if (pick < 95) t = gen_time - $urandom_range(1, 1000);
                else t = longint'($signed($urandom));
                t = longint'($signed(t[31:0]));
                if (t < gen_time) gen_fill = 0;
                gen_time = t;
                gen_fill = (gen_fill >= len) ? len : gen_fill + 1;
                push_item(KIND_ADD, t, v);
            end
            else begin
                lo = gen_time - sp * longint'((gen_fill > 0) ? gen_fill - 1 : 0);
                if (pick < 65 && gen_fill > 1)
                    t = lo + longint'($urandom_range(gen_fill - 2)) * sp +
                        longint'($urandom_range(sp - 1));
                else if (pick < 75) t = gen_time;
                else if (pick < 82) t = lo;
                else if (pick < 88) t = gen_time + 1;
                else if (pick < 94) t = lo - 1;
                else t = longint'($signed($urandom));
                push_item(KIND_QUERY, t, v);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty window, extremes, boundaries, clear on a backward time.
        push_item(KIND_QUERY, 0, 32'h0);
        push_item(KIND_ADD, 0, 32'h7FFFFFFF);
        push_item(KIND_QUERY, 0, 32'hFFFFFFFF);
        push_item(KIND_ADD, 65536, 32'h80000000);
        push_item(KIND_QUERY, 32768, 32'h0);
        push_item(KIND_QUERY, 0, 32'h0);
        push_item(KIND_QUERY, 65536, 32'h0);
        push_item(KIND_QUERY, 65537, 32'h0);
        push_item(KIND_QUERY, -1, 32'h0);
        push_item(KIND_ADD, 131072, 32'hFFFFFFFF);
        push_item(KIND_QUERY, 98305, 32'h0);
        push_item(KIND_ADD, -65536, 32'd5);
        push_item(KIND_QUERY, -65536, 32'h0);
        push_item(KIND_QUERY, 0, 32'h0);
        push_item(KIND_ADD, -65536, 32'd9);
        push_item(KIND_QUERY, -131072, 32'h0);
        push_item(KIND_QUERY, -98304, 32'h0);
        push_item(KIND_ADD, 32'sh7FFFFFFF, 32'h12345678);
        push_item(KIND_QUERY, 32'sh7FFFFFFF, 32'h0);
        push_item(KIND_QUERY, -32'sh80000000, 32'h0);
        push_item(KIND_ADD, -32'sh80000000, 32'h1);
        push_item(KIND_QUERY, -32'sh80000000, 32'h0);
        gen_time = -32'sh80000000;
        gen_fill = 1;
        wait_idle();

        write_config(31'd1, 9'd1);
        fill_random(110, 50, 0);
        wait_idle();
        write_config(31'd0, 9'd0);
        fill_random(110, 50, 0);
        wait_idle();
        write_config(31'd65536, 9'd511);
        fill_random(300, 92, 0);
        wait_idle();
        write_config(31'h7FFFFFFF, 9'd2);
        fill_random(100, 50, 0);
        wait_idle();
        write_config(31'd3, 9'd8);
        fill_random(110, 60, 0);
        wait_idle();
        // The window shrinks while full; the first queries still see every sample.
        write_config(31'd3, 9'd3);
        fill_random(110, 50, 4);
        wait_idle();
        write_config(31'd7, 9'd256);
        fill_random(150, 70, 0);
        wait_idle();
        write_config(31'($urandom_range(1, 100000)), 9'($urandom_range(2, 40)));
        fill_random(150, 55, 0);
        wait_idle();

        if (expected_answers.size() != 0)
            report_mismatch("results left over", 0, expected_answers.size());
        if (errors == 0) begin
            $display("TB_OK");
        end
        else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/sswi_pkg.sv
rtl/core/sswi_ram.sv
rtl/core/sswi_fifo.sv
rtl/core/sswi_div.sv
rtl/core/sswi_back.sv
rtl/core/sliding_sample_window_interpolator.sv
sim/testbench.sv
